// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/i2cmrt_pkg.sv =====
// package for the i2c master register transfer block
// types and constants for the bus sequencer; no dependencies
package i2cmrt_pkg;
    localparam int CountBits = 16;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_BYTE  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [9:0] {
        PH_IDLE    = 10'b00_0000_0001,
        PH_START_W = 10'b00_0000_0010,
        PH_ADDR_W  = 10'b00_0000_0100,
        PH_REG_HI  = 10'b00_0000_1000,
        PH_REG_LO  = 10'b00_0001_0000,
        PH_START_R = 10'b00_0010_0000,
        PH_ADDR_R  = 10'b00_0100_0000,
        PH_DATA_W  = 10'b00_1000_0000,
        PH_DATA_R  = 10'b01_0000_0000,
        PH_STOP    = 10'b10_0000_0000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ADDR_NAK = 2'd1,
        ST_REG_NAK  = 2'd2,
        ST_DATA_NAK = 2'd3
    } t_status;

    localparam int InWidth  = 56;
    localparam int OutWidth = 16;
endpackage

// ===== rtl/i2c_master_register_transfer.sv =====
// Usage: requests enter on the s_axis channel, one per cycle at most. Each request
// is a time tick (opcode 0), a transaction begin (opcode 1), a write byte
// (opcode 2) or a no-op (opcode 3). For every accepted request exactly one result
// leaves on m_axis, carrying the pin levels (scl, sda_out, sda_drive), need_byte,
// a read byte with its valid flag, the done pulse, the last status and busy.
// The result is registered: a request taken at a clock edge shows on m_axis in
// the cycle after it. One request per cycle is taken while the result register
// is free or being taken; the bus sequencer step is a single pass of logic
// between the state registers and the result register. When the receiver stalls,
// the result register holds and s_axis_tready falls only if the result register
// is full and not taken, so the block keeps pace. Reset (synchronous, active low)
// returns the sequencer to idle, clears the result valid flag, loads ticks_per_step
// = 1, ack_poll_limit = 250, and releases SDA with SCL high. Configuration writes on
// cfg (index 0 ticks_per_step, index 1 ack_poll_limit) are always accepted.
`include "assert_macros.svh"
module i2c_master_register_transfer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: opcode[1:0], sda_in[2], is_read[3], device_type[5:4],
    // dev_addr[13:6], reg_ptr[29:14], byte_count[45:30],
    // write_byte[53:46], zero fill[55:54]
    input  logic [i2cmrt_pkg::InWidth-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: scl[0], sda_out[1], sda_drive[2], need_byte[3], read_byte[11:4],
    // read_valid[12], done_res[13], status[15:14]
    output logic [i2cmrt_pkg::OutWidth-1:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // tuser: busy_res
    output logic        m_axis_tuser
);
    import i2cmrt_pkg::*;

    // configuration
    logic [7:0] r_tps, r_apl;
    // sequencer state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_micro, n_micro;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [9:0]  r_timer, n_timer;
    logic [7:0]  r_polls, n_polls;
    logic [CountBits-1:0] r_left, n_left;
    logic [15:0] r_reg, n_reg;
    logic [7:0]  r_slave, n_slave;
    logic [2:0]  r_mode, n_mode;
    logic [7:0]  r_pend, n_pend;
    logic        r_pvalid, n_pvalid;
    t_status     r_stat, n_stat;
    logic        r_scl, n_scl, r_sda, n_sda, r_drv, n_drv;
    // result register
    logic        r_ovalid;
    logic [OutWidth-1:0] r_odata;
    logic        r_obusy;

    logic        accept;
    t_opcode     op;
    logic        sda_in, rx, done;
    logic [7:0]  tx_byte;
    logic [8:0]  poll_next;
    logic [7:0]  tps_eff;
    logic [9:0]  w1, w2, w4;
    logic        nd_next;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = t_opcode'(s_axis_tdata[1:0]);
    assign sda_in        = s_axis_tdata[2];

    // delay reload values: units*tps - 1, kept to ten bits
    assign tps_eff = (r_tps == 8'd0) ? 8'd1 : r_tps;
    assign w1      = {2'b00, tps_eff} - 10'd1;
    assign w2      = {1'b0, tps_eff, 1'b0} - 10'd1;
    assign w4      = {tps_eff, 2'b00} - 10'd1;
    assign poll_next = {1'b0, r_polls} + 9'd1;

    // byte to shift out for address and register phases
    always_comb begin
        case (r_phase)
            PH_ADDR_W: tx_byte = (r_mode[1:0] == 2'd3)
                ? ({r_slave[7:1], 1'b0} + {r_reg[14:8], 1'b0}) : {r_slave[7:1], 1'b0};
            PH_REG_HI: tx_byte = r_reg[15:8];
            PH_REG_LO: tx_byte = r_reg[7:0];
            default:   tx_byte = {r_slave[7:1], 1'b1};
        endcase
    end

    // one step of the bus sequencer
    always_comb begin
        n_phase = r_phase; n_micro = r_micro; n_bit = r_bit; n_shift = r_shift;
        n_timer = r_timer; n_polls = r_polls; n_left = r_left; n_reg = r_reg;
        n_slave = r_slave; n_mode = r_mode; n_pend = r_pend; n_pvalid = r_pvalid;
        n_stat = r_stat; n_scl = r_scl; n_sda = r_sda; n_drv = r_drv;
        rx = 1'b0; done = 1'b0;
        case (op)
            OP_TICK: begin
                if (r_phase == PH_IDLE) begin
                    n_phase = r_phase;
                end else if (r_timer != 10'd0) begin
                    n_timer = r_timer - 10'd1;
                end else begin
                    case (r_phase)
                        PH_START_W, PH_START_R: begin
                            if (r_micro == 3'd0) begin
                                n_drv = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                                n_timer = w4; n_micro = 3'd1;
                            end else begin
                                n_sda = 1'b0; n_timer = w4; n_micro = 3'd0;
                                n_phase = (r_phase == PH_START_W) ? PH_ADDR_W : PH_ADDR_R;
                            end
                        end
                        PH_DATA_R: begin
                            case (r_micro)
                                3'd0: begin
                                    n_drv = 1'b0; n_sda = 1'b1; n_bit = 4'd0;
                                    n_shift = 8'd0; n_timer = w2; n_micro = 3'd1;
                                end
                                3'd1: begin
                                    n_scl = 1'b1; n_shift = {r_shift[6:0], sda_in};
                                    n_timer = w2; n_micro = 3'd2;
                                end
                                3'd2: begin
                                    n_scl = 1'b0; n_bit = r_bit + 4'd1;
                                    if (r_bit + 4'd1 < 4'd8) begin
                                        n_timer = w2; n_micro = 3'd1;
                                    end else begin
                                        rx = 1'b1; n_left = r_left - CountBits'(1);
                                        n_drv = 1'b1;
                                        n_sda = (r_left - CountBits'(1)) == '0;
                                        n_timer = w2; n_micro = 3'd3;
                                    end
                                end
                                3'd3: begin
                                    n_scl = 1'b1; n_timer = w2; n_micro = 3'd4;
                                end
                                default: begin
                                    n_scl = 1'b0; n_micro = 3'd0;
                                    if (r_left == '0) begin
                                        n_timer = w1; n_phase = PH_STOP;
                                    end else begin
                                        n_timer = w2;
                                    end
                                end
                            endcase
                        end
                        PH_STOP: begin
                            case (r_micro)
                                3'd0: begin
                                    n_drv = 1'b1; n_sda = 1'b0; n_timer = w1;
                                    n_micro = 3'd1;
                                end
                                3'd1: begin n_scl = 1'b1; n_timer = w4; n_micro = 3'd2; end
                                3'd2: begin n_sda = 1'b1; n_timer = w4; n_micro = 3'd3; end
                                default: begin
                                    n_phase = PH_IDLE; n_micro = 3'd0; done = 1'b1;
                                end
                            endcase
                        end
                        default: begin
                            case (r_micro)
                                3'd0: begin
                                    if (r_phase != PH_DATA_W || r_pvalid) begin
                                        if (r_phase == PH_DATA_W) begin
                                            n_shift = r_pend; n_pvalid = 1'b0;
                                            n_left = r_left - CountBits'(1);
                                        end else begin
                                            n_shift = tx_byte;
                                        end
                                        n_drv = 1'b1; n_scl = 1'b0; n_bit = 4'd0;
                                        n_timer = w1; n_micro = 3'd1;
                                    end
                                end
                                3'd1: begin
                                    n_sda = r_shift[7]; n_shift = {r_shift[6:0], 1'b0};
                                    n_timer = w1; n_micro = 3'd2;
                                end
                                3'd2: begin n_scl = 1'b1; n_timer = w2; n_micro = 3'd3; end
                                3'd3: begin
                                    n_scl = 1'b0; n_timer = w1; n_bit = r_bit + 4'd1;
                                    n_micro = (r_bit + 4'd1 < 4'd8) ? 3'd1 : 3'd4;
                                end
                                3'd4: begin
                                    n_drv = 1'b0; n_sda = 1'b1; n_timer = w1;
                                    n_micro = 3'd5;
                                end
                                3'd5: begin
                                    n_scl = 1'b1; n_timer = w1; n_polls = 8'd0;
                                    n_micro = 3'd6;
                                end
                                default: begin
                                    if (!sda_in) begin
                                        n_scl = 1'b0; n_timer = w1; n_micro = 3'd0;
                                        case (r_phase)
                                            PH_ADDR_W: begin
                                                if (r_mode[1:0] == 2'd0)
                                                    n_phase = r_mode[2] ? PH_START_R
                                                        : (r_left != '0 ? PH_DATA_W : PH_STOP);
                                                else if (r_mode[1:0] == 2'd2)
                                                    n_phase = PH_REG_HI;
                                                else
                                                    n_phase = PH_REG_LO;
                                            end
                                            PH_REG_HI: n_phase = PH_REG_LO;
                                            PH_REG_LO: n_phase = r_mode[2] ? PH_START_R
                                                : (r_left != '0 ? PH_DATA_W : PH_STOP);
                                            PH_ADDR_R: n_phase = PH_DATA_R;
                                            default: n_phase = (r_left != '0) ? PH_DATA_W
                                                : PH_STOP;
                                        endcase
                                    end else if (poll_next > {1'b0, r_apl}) begin
                                        if (r_phase == PH_ADDR_W) n_stat = ST_ADDR_NAK;
                                        else if (r_phase == PH_REG_HI || r_phase == PH_REG_LO)
                                            n_stat = ST_REG_NAK;
                                        else n_stat = ST_DATA_NAK;
                                        n_drv = 1'b1; n_sda = 1'b0; n_timer = w1;
                                        n_phase = PH_STOP; n_micro = 3'd1;
                                    end else begin
                                        n_polls = poll_next[7:0];
                                    end
                                end
                            endcase
                        end
                    endcase
                end
            end
            OP_BEGIN: begin
                if (r_phase == PH_IDLE) begin
                    n_mode  = {s_axis_tdata[3], s_axis_tdata[5:4]};
                    n_slave = s_axis_tdata[13:6];
                    n_reg   = s_axis_tdata[29:14];
                    n_left  = s_axis_tdata[30 +: CountBits];
                    if (s_axis_tdata[3] && s_axis_tdata[30 +: CountBits] == '0)
                        n_left = CountBits'(1);
                    n_pvalid = 1'b0; n_stat = ST_OK; n_polls = 8'd0;
                    n_micro = 3'd0; n_timer = 10'd0; n_bit = 4'd0;
                    n_phase = (s_axis_tdata[3] && s_axis_tdata[5:4] == 2'd0)
                        ? PH_START_R : PH_START_W;
                end
            end
            OP_BYTE: begin
                n_pend = s_axis_tdata[53:46]; n_pvalid = 1'b1;
            end
            default: n_phase = r_phase;
        endcase
        nd_next = (n_phase != PH_IDLE) && !n_mode[2] && (n_left != '0) && !n_pvalid;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= 8'd1; r_apl <= 8'd250;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == 1'b0) r_tps <= i_cfg_data;
            else r_apl <= i_cfg_data;
        end
    end

    // sequencer state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_micro <= 3'd0; r_bit <= 4'd0; r_shift <= 8'd0;
            r_timer <= 10'd0; r_polls <= 8'd0; r_left <= '0; r_reg <= 16'd0;
            r_slave <= 8'd0; r_mode <= 3'd0; r_pvalid <= 1'b0; r_stat <= ST_OK;
            r_scl <= 1'b1; r_sda <= 1'b1; r_drv <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase; r_micro <= n_micro; r_bit <= n_bit;
                r_shift <= n_shift; r_timer <= n_timer; r_polls <= n_polls;
                r_left <= n_left; r_reg <= n_reg; r_slave <= n_slave;
                r_mode <= n_mode; r_pvalid <= n_pvalid; r_stat <= n_stat;
                r_scl <= n_scl; r_sda <= n_sda; r_drv <= n_drv;
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend  <= n_pend;
            r_odata <= {n_stat, done, rx, (rx ? n_shift : 8'd0), nd_next, n_drv, n_sda,
                        n_scl};
            r_obusy <= (n_phase != PH_IDLE);
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_obusy;

    // checks
    `ASSERT_NEXT(a_hold_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_IMP(a_idle_pins, r_phase == PH_IDLE && r_micro != 3'd0, 1'b0)
    `ASSERT_IMP(a_bit_range, r_phase != PH_IDLE, r_bit <= 4'd8)
endmodule

// ===== test/tb_i2c_master_register_transfer.sv =====
// testbench for the i2c master register transfer block
// drives register write and read transfers tick by tick against a bus-level predictor
// depends on rtl/i2cmrt_pkg.sv and rtl/i2c_master_register_transfer.sv
module tb_i2c_master_register_transfer;
    import i2cmrt_pkg::*;

    localparam int StallLimit = 5000;
    localparam int LongHold   = 150;
    localparam int ItemTarget = 750;

    // one request as packed on s_axis_tdata, lowest field last
    typedef struct packed {
        logic [1:0]  pad;
        logic [7:0]  wbyte;
        logic [15:0] count;
        logic [15:0] reg_addr;
        logic [7:0]  slave;
        logic [1:0]  dev_type;
        logic        rd;
        logic        sda;
        logic [1:0]  op;
    } t_req;

    // one result as packed on m_axis_tdata, plus busy from tuser
    typedef struct packed {
        logic        busy;
        logic [1:0]  status;
        logic        done;
        logic        rvalid;
        logic [7:0]  rbyte;
        logic        need;
        logic        drv;
        logic        sda;
        logic        scl;
    } t_bus_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InWidth-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutWidth-1:0] m_axis_tdata;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [7:0]          i_cfg_data;
    logic                m_axis_tuser;

    i2c_master_register_transfer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_bus_result expected_results[$];
    int          err_count;
    int          items_sent;
    int          results_seen;
    int          transfers_run;
    int          stall_cycles;
    bit          idle_on;
    bit          long_hold;

    // predictor state
    t_phase      bus_ph;
    int unsigned micro, bit_idx, shf, dly, polls, left;
    int unsigned hreg, hslv, hmode, pbyte, pvalid, lstat;
    int unsigned pscl, psda, pdrv, tps, apl;
    bit          rx_flag, done_flag;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic void predictor_reset();
        tps = 1; apl = 250;
        bus_ph = PH_IDLE; micro = 0; bit_idx = 0; shf = 0; dly = 0; polls = 0; left = 0;
        hreg = 0; hslv = 0; hmode = 0; pbyte = 0; pvalid = 0; lstat = 0;
        pscl = 1; psda = 1; pdrv = 0;
    endfunction

    function automatic void hold_units(int unsigned units);
        int unsigned t;
        t = (tps != 0) ? tps : 1;
        dly = (units != 0) ? ((units * t - 1) & 10'h3FF) : 0;
    endfunction

    function automatic int unsigned addressing_byte();
        case (bus_ph)
            PH_ADDR_W: begin
                // type 3 folds the register high bits into the address
                if ((hmode & 3) == 3) return ((hslv & 8'hFE) + ((hreg >> 8) << 1)) & 8'hFF;
                return hslv & 8'hFE;
            end
            PH_REG_HI: return hreg >> 8;
            PH_REG_LO: return hreg & 8'hFF;
            default:   return (hslv | 8'h01) & 8'hFF;
        endcase
    endfunction

    function automatic void to_write_data();
        bus_ph = (left != 0) ? PH_DATA_W : PH_STOP;
    endfunction

    function automatic void next_phase();
        int unsigned dt;
        bit rd;
        dt = hmode & 3;
        rd = (hmode & 4) != 0;
        case (bus_ph)
            PH_ADDR_W: begin
                if (dt == 0) begin
                    if (rd) bus_ph = PH_START_R;
                    else to_write_data();
                end else if (dt == 2) bus_ph = PH_REG_HI;
                else bus_ph = PH_REG_LO;
            end
            PH_REG_HI: bus_ph = PH_REG_LO;
            PH_REG_LO: begin
                if (rd) bus_ph = PH_START_R;
                else to_write_data();
            end
            PH_ADDR_R: bus_ph = PH_DATA_R;
            default: to_write_data();
        endcase
        micro = 0;
    endfunction

    // send a byte, then poll for acknowledge
    function automatic void send_step(bit sda_in);
        int unsigned n;
        case (micro)
            0: begin
                if (bus_ph == PH_DATA_W) begin
                    if (pvalid == 0) return;
                    shf = pbyte & 8'hFF;
                    pvalid = 0;
                    left = (left - 1) & 16'hFFFF;
                end else begin
                    shf = addressing_byte();
                end
                pdrv = 1; pscl = 0; bit_idx = 0;
                hold_units(1); micro = 1;
            end
            1: begin
                psda = (shf >> 7) & 1;
                shf = (shf << 1) & 8'hFF;
                hold_units(1); micro = 2;
            end
            2: begin
                pscl = 1; hold_units(2); micro = 3;
            end
            3: begin
                pscl = 0; hold_units(1);
                bit_idx = (bit_idx + 1) & 4'hF;
                micro = (bit_idx < 8) ? 1 : 4;
            end
            4: begin
                pdrv = 0; psda = 1; hold_units(1); micro = 5;
            end
            5: begin
                pscl = 1; hold_units(1); polls = 0; micro = 6;
            end
            default: begin
                if (!sda_in) begin
                    pscl = 0; hold_units(1); next_phase();
                end else begin
                    n = polls + 1;
                    if (n > apl) begin
                        // acknowledge timeout: status depends on the byte in flight
                        if (bus_ph == PH_ADDR_W) lstat = ST_ADDR_NAK;
                        else if (bus_ph == PH_REG_HI || bus_ph == PH_REG_LO) lstat = ST_REG_NAK;
                        else lstat = ST_DATA_NAK;
                        pdrv = 1; psda = 0; hold_units(1);
                        bus_ph = PH_STOP; micro = 1;
                    end else begin
                        polls = n & 8'hFF;
                    end
                end
            end
        endcase
    endfunction

    // receive a byte, then answer ack or nack on the last
    function automatic void receive_step(bit sda_in);
        case (micro)
            0: begin
                pdrv = 0; psda = 1; bit_idx = 0; shf = 0;
                hold_units(2); micro = 1;
            end
            1: begin
                pscl = 1;
                shf = ((shf << 1) | sda_in) & 8'hFF;
                hold_units(2); micro = 2;
            end
            2: begin
                pscl = 0;
                bit_idx = (bit_idx + 1) & 4'hF;
                if (bit_idx < 8) begin
                    hold_units(2); micro = 1;
                end else begin
                    rx_flag = 1;
                    left = (left - 1) & 16'hFFFF;
                    pdrv = 1; psda = (left == 0) ? 1 : 0;
                    hold_units(2); micro = 3;
                end
            end
            3: begin
                pscl = 1; hold_units(2); micro = 4;
            end
            default: begin
                pscl = 0;
                if (left == 0) begin
                    hold_units(1); bus_ph = PH_STOP;
                end else begin
                    hold_units(2);
                end
                micro = 0;
            end
        endcase
    endfunction

    function automatic void stop_step();
        case (micro)
            0: begin pdrv = 1; psda = 0; hold_units(1); micro = 1; end
            1: begin pscl = 1; hold_units(4); micro = 2; end
            2: begin psda = 1; hold_units(4); micro = 3; end
            default: begin bus_ph = PH_IDLE; micro = 0; done_flag = 1; end
        endcase
    endfunction

    function automatic void tick_step(bit sda_in);
        if (bus_ph == PH_IDLE) return;
        if (dly != 0) begin
            dly--;
            return;
        end
        case (bus_ph)
            PH_START_W, PH_START_R: begin
                if (micro == 0) begin
                    pdrv = 1; psda = 1; pscl = 1; hold_units(4); micro = 1;
                end else begin
                    psda = 0; hold_units(4);
                    bus_ph = (bus_ph == PH_START_W) ? PH_ADDR_W : PH_ADDR_R;
                    micro = 0;
                end
            end
            PH_DATA_R: receive_step(sda_in);
            PH_STOP:   stop_step();
            default:   send_step(sda_in);
        endcase
    endfunction

    function automatic bit wants_byte();
        return bus_ph != PH_IDLE && (hmode & 4) == 0 && left != 0 && pvalid == 0;
    endfunction

    function automatic t_bus_result bus_step(t_req r);
        t_bus_result res;
        rx_flag = 0;
        done_flag = 0;
        case (t_opcode'(r.op))
            OP_TICK: tick_step(r.sda);
            OP_BEGIN: begin
                // a begin while busy is dropped
                if (bus_ph == PH_IDLE) begin
                    hmode = (r.rd << 2) | r.dev_type;
                    hslv = r.slave;
                    hreg = r.reg_addr;
                    left = r.count;
                    if (r.rd && left == 0) left = 1;
                    pvalid = 0; lstat = ST_OK; polls = 0;
                    micro = 0; dly = 0; bit_idx = 0;
                    bus_ph = (r.rd && r.dev_type == 0) ? PH_START_R : PH_START_W;
                end
            end
            OP_BYTE: begin
                pbyte = r.wbyte;
                pvalid = 1;
            end
            default: ;
        endcase
        res.scl    = pscl[0];
        res.sda    = psda[0];
        res.drv    = pdrv[0];
        res.need   = wants_byte();
        res.rbyte  = rx_flag ? shf[7:0] : 8'h00;
        res.rvalid = rx_flag;
        res.done   = done_flag;
        res.status = lstat[1:0];
        res.busy   = bus_ph != PH_IDLE;
        return res;
    endfunction

    // ---------------- drivers ----------------
    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got,
                 want);
        err_count++;
    endtask

    // send one request; entered and left at a falling edge
    task automatic send_item(t_req r);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(bus_step(r));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic quiet_input();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        quiet_input();
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(bit idx, logic [7:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == 1'b0) tps = value;
        else apl = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_req tick_req(bit sda);
        t_req r;
        r = '0;
        r.op = OP_TICK;
        r.sda = sda;
        r.wbyte = 8'($urandom);
        r.reg_addr = 16'($urandom);
        return r;
    endfunction

    // one transfer from begin to stop; nack_pct biases the acknowledge polls
    task automatic run_transfer(bit rd, logic [1:0] dt, logic [7:0] slave,
                                logic [15:0] reg_addr, logic [15:0] count, int nack_pct);
        t_req r;
        bit   in_ack;
        r = '0;
        r.op = OP_BEGIN;
        r.rd = rd;
        r.dev_type = dt;
        r.slave = slave;
        r.reg_addr = reg_addr;
        r.count = count;
        r.sda = 1'($urandom);
        r.wbyte = 8'($urandom);
        send_item(r);
        transfers_run++;
        while (bus_ph != PH_IDLE) begin
            in_ack = micro == 6 && bus_ph != PH_DATA_R && bus_ph != PH_STOP &&
                     bus_ph != PH_START_W && bus_ph != PH_START_R;
            r = tick_req(in_ack ? ($urandom_range(0, 99) < nack_pct)
                                : 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 29) == 0) begin
                // noise: unused opcode, begin while busy, or a stray byte
                r.op = 2'($urandom_range(1, 3));
                r.rd = 1'($urandom);
                r.dev_type = 2'($urandom);
                r.slave = 8'($urandom);
                r.count = 16'($urandom);
            end else if (wants_byte() && $urandom_range(0, 1) == 0) begin
                r.op = OP_BYTE;
            end
            send_item(r);
        end
    endtask

    // ---------------- checking ----------------
    always @(posedge i_clk) begin
        t_bus_result want;
        t_bus_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata};
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", got, 0);
            end else begin
                want = expected_results.pop_front();
                if (got.scl !== want.scl) report_mismatch("scl", got.scl, want.scl);
                if (got.sda !== want.sda) report_mismatch("sda_out", got.sda, want.sda);
                if (got.drv !== want.drv) report_mismatch("sda_drive", got.drv, want.drv);
                if (got.need !== want.need) report_mismatch("need_byte", got.need, want.need);
                if (got.rbyte !== want.rbyte) report_mismatch("read_byte", got.rbyte, want.rbyte);
                if (got.rvalid !== want.rvalid)
                    report_mismatch("read_valid", got.rvalid, want.rvalid);
                if (got.done !== want.done) report_mismatch("done", got.done, want.done);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.busy !== want.busy) report_mismatch("busy", got.busy, want.busy);
            end
            results_seen++;
        end
    end

    // receiver: random hold-offs per result, and one long hold when asked
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                stall_cycles = 0;
                while (stall_cycles < LongHold) begin
                    @(negedge i_clk);
                    stall_cycles++;
                end
                long_hold = 1'b0;
            end
            gap = idle_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // watchdog on cycles with no request, result or configuration write moving
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= StallLimit) begin
                $display("timeout: nothing moved for %0d cycles", quiet);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_noise_while_idle();
        t_req r;
        r = tick_req(1'b1);
        send_item(r);
        r.op = OP_NONE;
        send_item(r);
        r.op = OP_BYTE;
        r.wbyte = 8'hFF;
        send_item(r);
        r = tick_req(1'b0);
        send_item(r);
    endtask

    task automatic test_write_layouts();
        // type 3 adds register high bits into the address
        run_transfer(1'b0, 2'd3, 8'hFF, 16'hFFFF, 16'd1, 0);
        // two register bytes with a zero count: address and register only
        run_transfer(1'b0, 2'd2, 8'hA5, 16'h5AC3, 16'd0, 0);
    endtask

    task automatic test_read_layouts();
        // no register phase: straight to the read address
        run_transfer(1'b1, 2'd0, 8'h50, 16'h1234, 16'd1, 0);
        // zero read count still reads one byte
        run_transfer(1'b1, 2'd1, 8'h42, 16'h0011, 16'd0, 0);
    endtask

    task automatic test_ack_timeouts();
        write_register(1'b1, 8'd0);
        run_transfer(1'b0, 2'd1, 8'h80, 16'h0001, 16'd1, 100);
        write_register(1'b1, 8'd250);
    endtask

    task automatic test_step_scaling();
        // doubled step, ended early by a nack on the read address (a data nack status)
        write_register(1'b0, 8'd2);
        write_register(1'b1, 8'd0);
        run_transfer(1'b1, 2'd0, 8'h66, 16'h0000, 16'd1, 100);
        write_register(1'b0, 8'd1);
        write_register(1'b1, 8'd250);
    endtask

    task automatic test_output_backpressure();
        idle_on = 1'b0;
        long_hold = 1'b1;
        run_transfer(1'b0, 2'd0, 8'h9A, 16'hBEEF, 16'd1, 0);
        idle_on = 1'b1;
    endtask

    task automatic test_random_transfers();
        do begin
            if ($urandom_range(0, 2) == 0) write_register(1'b0, 8'($urandom_range(0, 2)));
            if ($urandom_range(0, 2) == 0) write_register(1'b1, 8'($urandom_range(0, 4)));
            idle_on = $urandom_range(0, 3) != 0;
            run_transfer(1'($urandom), 2'($urandom), 8'($urandom), 16'($urandom),
                         ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 2)),
                         $urandom_range(0, 3) == 0 ? 40 : 5);
        end while (items_sent < ItemTarget);
        idle_on = 1'b1;
    endtask

    initial begin
        err_count = 0;
        items_sent = 0;
        results_seen = 0;
        transfers_run = 0;
        idle_on = 1'b1;
        long_hold = 1'b0;
        predictor_reset();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = 8'h00;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_noise_while_idle();
        test_write_layouts();
        test_read_layouts();
        test_ack_timeouts();
        test_step_scaling();
        test_output_backpressure();
        test_random_transfers();

        drain();
        if (expected_results.size() != 0)
            report_mismatch("results left over", expected_results.size(), 0);
        $display("covered %0d transfers over %0d requests and %0d results,",
                 transfers_run, items_sent, results_seen);
        $display("device layouts, reads and writes, nack timeouts, step scaling and stalls");
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
